[design/ard_rbf_kernel_evaluator_core_defines.svh]
// Assertion macros for the ARD kernel evaluator core.
// Included by the top level; no other dependencies.
`ifndef ARD_RBF_KERNEL_EVALUATOR_CORE_DEFINES_SVH
`define ARD_RBF_KERNEL_EVALUATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check prop on every rising clock edge outside reset.
`define ARDK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ardk assertion failed");
// Check cons in the cycle after ante.
`define ARDK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
      else $error("ardk assertion failed");
`else
`define ARDK_ASSERT(lbl, clk, rst, prop)
`define ARDK_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[design/ardk_pkg.sv]
// Shared types and constants of the ARD kernel evaluator.
// Used by ardk_cell, ardk_tail and the top level; no dependencies.
`default_nettype none
package ardk_pkg;

   localparam int DIM     = 4;
   localparam int NREG    = DIM + 1;
   localparam int AW      = $clog2(4 * NREG);
   localparam int RIDX_W  = AW - 2;
   localparam int TAIL_STAGES = 10;

   typedef enum logic [1:0] {
      ACT_KERNEL = 2'd0,
      ACT_FIRST  = 2'd1,
      ACT_SECOND = 2'd2,
      ACT_HYPER  = 2'd3
   } action_type;

   localparam logic [RIDX_W-1:0] REG_AMPLITUDE    = RIDX_W'(0);
   localparam logic [RIDX_W-1:0] REG_INV_LENGTH_0 = RIDX_W'(1);
   localparam logic [15:0]       CFG_RESET        = 16'd256;

   localparam logic [21:0] H_SAT     = 22'd2097152;
   localparam logic [21:0] H_CAP     = 22'd1572864;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [16:0] EXP_C0    = 17'd630;
   localparam logic [16:0] EXP_C1    = 17'd3638;
   localparam logic [16:0] EXP_C2    = 17'd15744;
   localparam logic [16:0] EXP_C3    = 17'd45426;
   localparam logic [16:0] EXP_C4    = 17'd65536;
   localparam logic [62:0] MAG_CAP   = 63'h4000_0000_0000_0000;

   typedef struct packed {
      action_type             action;
      logic [2:0]             first_index;
      logic [1:0]             second_index;
      logic [DIM-1:0][15:0]   pa;
      logic [DIM-1:0][15:0]   pb;
      logic [DIM-1:0][15:0]   s;
      logic [DIM-1:0][31:0]   t;
      logic [DIM-1:0]         dneg;
      logic [21:0]            h;
   } item_type;

   typedef struct packed {
      item_type    item;
      logic [31:0] tk;
      logic        nk;
   } cell_mid_type;

   typedef struct packed {
      action_type  action;
      logic [2:0]  fi;
      logic        bad;
      logic        same;
      logic        neg_a;
      logic        neg_j;
      logic [15:0] amp;
      logic [31:0] amp2;
      logic [5:0]  n;
      logic [15:0] f;
      logic [16:0] p;
      logic [63:0] pa_prod;
      logic [47:0] qj_prod;
      logic [31:0] sq;
      logic [15:0] sm;
      logic [46:0] x1;
      logic        x1c;
      logic [39:0] uj;
      logic [63:0] pp_ll;
      logic [39:0] pp_lh;
      logic [46:0] pp_hl;
      logic [22:0] pp_hh;
      logic        bnz;
      logic [54:0] x2;
      logic        x2c;
      logic [31:0] kval;
      logic [25:0] ampe;
      logic [63:0] pk_lo;
      logic [54:0] pk_hi;
      logic [63:0] qk;
      logic [62:0] x3;
      logic [62:0] q;
      logic [31:0] result;
      logic        sat;
   } tail_type;

endpackage
`default_nettype wire

[design/ardk_cell.sv]
// One dimension cell of the distance chain: |a-b|*s, then its squared term into h.
// Depends on ardk_pkg.
`default_nettype none
module ardk_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ardk_pkg::item_type in_item,
   output logic              in_stall,
   output logic              out_valid,
   output ardk_pkg::item_type out_item,
   input  logic              out_stall
);
   import ardk_pkg::*;

   logic         mid_valid_ff, mid_valid_in;
   cell_mid_type mid_ff, mid_in;
   logic         out_valid_ff, out_valid_in;
   item_type     out_ff, out_in;
   logic         mid_adv, out_adv;

   assign out_adv  = !out_valid_ff || !out_stall;
   assign mid_adv  = !mid_valid_ff || out_adv;
   assign in_stall = mid_valid_ff && !out_adv;
   assign mid_valid_in = mid_adv ? in_valid : mid_valid_ff;
   assign out_valid_in = out_adv ? mid_valid_ff : out_valid_ff;

   // difference and scaled magnitude of the leading coordinate; rotate vectors
   always_comb begin
      logic signed [16:0] d;
      logic [15:0]        dmag;
      d    = $signed({in_item.pa[0][15], in_item.pa[0]})
           - $signed({in_item.pb[0][15], in_item.pb[0]});
      dmag = d[16] ? 16'(-d) : d[15:0];
      mid_in = '0;
      mid_in.item = in_item;
      for (int j = 0; j < DIM - 1; j++) begin
         mid_in.item.pa[j] = in_item.pa[j+1];
         mid_in.item.pb[j] = in_item.pb[j+1];
         mid_in.item.s[j]  = in_item.s[j+1];
      end
      mid_in.item.pa[DIM-1] = in_item.pa[0];
      mid_in.item.pb[DIM-1] = in_item.pb[0];
      mid_in.item.s[DIM-1]  = in_item.s[0];
      mid_in.tk = dmag * in_item.s[0];
      mid_in.nk = d[16];
   end

   // square term, capped sum, shift the term into the T vector
   always_comb begin
      logic [63:0] sq;
      logic [21:0] termc;
      logic [22:0] sum;
      sq    = mid_ff.tk * mid_ff.tk;
      termc = (sq[63:17] > 47'(H_SAT)) ? H_SAT : sq[38:17];
      sum   = {1'b0, mid_ff.item.h} + {1'b0, termc};
      out_in = mid_ff.item;
      out_in.h = (sum > {1'b0, H_SAT}) ? H_SAT : sum[21:0];
      for (int j = 0; j < DIM - 1; j++) begin
         out_in.t[j]    = mid_ff.item.t[j+1];
         out_in.dneg[j] = mid_ff.item.dneg[j+1];
      end
      out_in.t[DIM-1]    = mid_ff.tk;
      out_in.dneg[DIM-1] = mid_ff.nk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (mid_adv) mid_ff <= mid_in;
      if (out_adv) out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

endmodule
`default_nettype wire

[design/ardk_tail.sv]
// Post-chain pipeline: exp approximation, derivative products, saturation.
// Depends on ardk_pkg.
`default_nettype none
module ardk_tail (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  ardk_pkg::item_type in_item,
   input  logic [15:0]        amp,
   output logic               in_stall,
   output logic               out_valid,
   output logic [31:0]        out_result,
   output logic               out_saturated,
   output logic               out_bad_index,
   input  logic               out_stall
);
   import ardk_pkg::*;

   logic     v_ff [TAIL_STAGES];
   logic     v_in [TAIL_STAGES];
   logic     adv  [TAIL_STAGES];
   logic     hold [TAIL_STAGES];
   tail_type st_ff [TAIL_STAGES];
   tail_type st_in [TAIL_STAGES];

   function automatic logic [16:0] exp_step(input logic [16:0] c, input logic [16:0] p,
                                            input logic [15:0] f);
      logic [32:0] m;
      m = p * f;
      return c - m[32:16];
   endfunction

   // advance a stage when it is empty or its successor moves
   always_comb begin
      hold[TAIL_STAGES-1] = out_stall;
      for (int k = TAIL_STAGES - 2; k >= 0; k--)
         hold[k] = v_ff[k+1] && hold[k+1];
      for (int k = 0; k < TAIL_STAGES; k++)
         adv[k] = !v_ff[k] || !hold[k];
      v_in[0] = adv[0] ? in_valid : v_ff[0];
      for (int k = 1; k < TAIL_STAGES; k++)
         v_in[k] = adv[k] ? v_ff[k-1] : v_ff[k];
   end
   assign in_stall = v_ff[0] && hold[0];

   always_comb begin
      logic [2:0]  ia;
      logic [31:0] ta, tj;
      logic [15:0] sa, sj;
      logic        na, nj;
      logic [20:0] hc;
      logic [37:0] y38;
      logic [39:0] bop;
      logic [86:0] prod, prod3;
      logic [49:0] ke;
      logic [32:0] ae;
      logic signed [63:0] sv;
      logic [62:0] mag;
      logic        neg;
      tail_type    c;

      // stage 0: operand select, exp argument, first products
      c = '0;
      c.action = in_item.action;
      c.fi     = in_item.first_index;
      ia = (in_item.action == ACT_HYPER) ? in_item.first_index - 3'd1 : in_item.first_index;
      ta = '0; tj = '0; sa = '0; sj = '0; na = 1'b0; nj = 1'b0;
      for (int k = 0; k < DIM; k++) begin
         if (ia == 3'(k)) begin
            ta = in_item.t[k]; sa = in_item.s[k]; na = in_item.dneg[k];
         end
         if ({1'b0, in_item.second_index} == 3'(k)) begin
            tj = in_item.t[k]; sj = in_item.s[k]; nj = in_item.dneg[k];
         end
      end
      unique case (in_item.action)
         ACT_KERNEL: c.bad = 1'b0;
         ACT_FIRST:  c.bad = in_item.first_index >= 3'(DIM);
         ACT_SECOND: c.bad = (in_item.first_index >= 3'(DIM))
                          || ({1'b0, in_item.second_index} >= 3'(DIM));
         ACT_HYPER:  c.bad = in_item.first_index > 3'(DIM);
         default:    c.bad = 1'b0;
      endcase
      c.same  = {1'b0, in_item.second_index} == in_item.first_index;
      c.neg_a = na;
      c.neg_j = nj;
      hc  = (in_item.h > H_CAP) ? H_CAP[20:0] : in_item.h[20:0];
      y38 = hc * LOG2E_Q16;
      c.n = y38[37:32];
      c.f = y38[31:16];
      c.amp  = amp;
      c.amp2 = amp * amp;
      c.pa_prod = ta * ((in_item.action == ACT_HYPER) ? ta : {16'b0, sa});
      c.qj_prod = tj * sj;
      c.sq = sa * sa;
      c.sm = sa;
      st_in[0] = c;

      // stage 1: first clamp/shift, exp step
      c = st_ff[0];
      c.p = exp_step(EXP_C1, EXP_C0, c.f);
      if (c.pa_prod > 64'(MAG_CAP)) begin
         c.x1c = 1'b1;
         c.x1  = '0;
      end else begin
         c.x1c = 1'b0;
         c.x1  = (c.action == ACT_HYPER) ? 47'(c.pa_prod >> 16) : 47'(c.pa_prod >> 8);
      end
      c.uj = c.qj_prod[47:8];
      st_in[1] = c;

      // stage 2: partial products of the second multiply
      c = st_ff[1];
      c.p = exp_step(EXP_C2, c.p, c.f);
      bop = (c.action == ACT_SECOND) ? c.uj : {24'b0, c.sm};
      c.pp_ll = c.x1[31:0] * bop[31:0];
      c.pp_lh = c.x1[31:0] * bop[39:32];
      c.pp_hl = c.x1[46:32] * bop[31:0];
      c.pp_hh = c.x1[46:32] * bop[39:32];
      c.bnz   = bop != '0;
      st_in[2] = c;

      // stage 3: sum partials, clamp/shift
      c = st_ff[2];
      c.p = exp_step(EXP_C3, c.p, c.f);
      prod = 87'(c.pp_ll) + (87'(c.pp_lh) << 32) + (87'(c.pp_hl) << 32)
           + (87'(c.pp_hh) << 64);
      if (c.action == ACT_FIRST) begin
         c.x2  = 55'(c.x1);
         c.x2c = c.x1c;
      end else begin
         c.x2c = (c.x1c && c.bnz) || (prod > 87'(MAG_CAP));
         if (c.x2c)                      c.x2 = '0;
         else if (c.action == ACT_SECOND) c.x2 = 55'(prod >> 16);
         else                            c.x2 = 55'(prod >> 8);
      end
      st_in[3] = c;

      // stage 4: last exp step
      c = st_ff[3];
      c.p = exp_step(EXP_C4, c.p, c.f);
      st_in[4] = c;

      // stage 5: integer part of the exponent as a shift
      c = st_ff[4];
      c.p = (c.n > 6'd16) ? 17'd0 : (c.p >> c.n);
      st_in[5] = c;

      // stage 6: kernel value and amplitude term
      c = st_ff[5];
      ke = c.amp2 * c.p;
      ae = c.amp * c.p;
      c.kval = ke[47:16];
      c.ampe = ae[32:7];
      st_in[6] = c;

      // stage 7: partial products with the kernel value
      c = st_ff[6];
      c.pk_lo = c.x2[31:0] * c.kval;
      c.pk_hi = c.x2[54:32] * c.kval;
      c.qk    = c.sq * c.kval;
      st_in[7] = c;

      // stage 8: combine, clamp/shift
      c = st_ff[7];
      prod3 = 87'(c.pk_lo) + (87'(c.pk_hi) << 32);
      if ((c.x2c && c.kval != '0) || prod3 > 87'(MAG_CAP)) c.x3 = MAG_CAP;
      else                                                c.x3 = 63'(prod3 >> 16);
      c.q = (c.qk > 64'(MAG_CAP)) ? MAG_CAP : 63'(c.qk >> 16);
      st_in[8] = c;

      // stage 9: select, sign, saturate
      c = st_ff[8];
      neg = 1'b0;
      mag = c.x3;
      sv  = '0;
      unique case (c.action)
         ACT_KERNEL: mag = 63'(c.kval);
         ACT_FIRST:  neg = !c.neg_a;
         ACT_SECOND: begin
            if (c.same) begin
               sv  = $signed({1'b0, c.x3}) - $signed({1'b0, c.q});
               neg = sv[63];
               mag = neg ? 63'(-sv) : sv[62:0];
            end else begin
               neg = c.neg_a ^ c.neg_j;
            end
         end
         ACT_HYPER: mag = (c.fi == 3'd0) ? 63'(c.ampe) : c.x3;
         default:   mag = c.x3;
      endcase
      priority if (c.bad) begin
         c.result = '0;
         c.sat    = 1'b0;
      end else if (!neg && mag > 63'h7FFF_FFFF) begin
         c.result = 32'h7FFF_FFFF;
         c.sat    = 1'b1;
      end else if (neg && mag > 63'h8000_0000) begin
         c.result = 32'h8000_0000;
         c.sat    = 1'b1;
      end else begin
         c.result = neg ? -mag[31:0] : mag[31:0];
         c.sat    = 1'b0;
      end
      st_in[9] = c;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < TAIL_STAGES; k++) begin
         if (reset) v_ff[k] <= 1'b0;
         else       v_ff[k] <= v_in[k];
         if (adv[k]) st_ff[k] <= st_in[k];
      end
   end

   assign out_valid     = v_ff[TAIL_STAGES-1];
   assign out_result    = st_ff[TAIL_STAGES-1].result;
   assign out_saturated = st_ff[TAIL_STAGES-1].sat;
   assign out_bad_index = st_ff[TAIL_STAGES-1].bad;

endmodule
`default_nettype wire

[design/ard_rbf_kernel_evaluator_core.sv]
// ARD squared-exponential kernel evaluator. Each transfer on the req_ channel carries two
// 4-D points (signed Q8.8), an action and up to two indices; one result transfer follows
// on rsp_ with a signed Q16.16 value, a saturation flag and a bad-index flag. The block
// takes one pair per clock and keeps taking them while results wait: a transfer is held
// back only when every stage is full and rsp_stall is high. A chain of DIM cells, two stages
// each, builds the scaled distances and the exponent argument, then ten stages evaluate
// exp, the derivative products and the final saturation. Amplitude and inverse
// lengthscales (unsigned Q8.8, reset 1.0) sit in APB registers at byte offsets 0, 4, 8,
// 12, 16; write them only while the pipeline is empty.
`default_nettype none
`include "ard_rbf_kernel_evaluator_core_defines.svh"
module ard_rbf_kernel_evaluator_core (
   input  logic                       clock,
   input  logic                       reset,
   // input transfers
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_action,
   input  logic signed [15:0]         req_point_a_0,
   input  logic signed [15:0]         req_point_a_1,
   input  logic signed [15:0]         req_point_a_2,
   input  logic signed [15:0]         req_point_a_3,
   input  logic signed [15:0]         req_point_b_0,
   input  logic signed [15:0]         req_point_b_1,
   input  logic signed [15:0]         req_point_b_2,
   input  logic signed [15:0]         req_point_b_3,
   input  logic [2:0]                 req_first_index,
   input  logic [1:0]                 req_second_index,
   // result transfers
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [31:0]         rsp_kernel_result,
   output logic                       rsp_saturated,
   output logic                       rsp_bad_index,
   // register port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ardk_pkg::AW-1:0]    paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import ardk_pkg::*;

   logic [15:0]          amp_ff, amp_in;
   logic [DIM-1:0][15:0] inv_ff, inv_in;
   logic [RIDX_W-1:0]    reg_idx;
   logic                 cfg_write;

   item_type chain_item  [DIM+1];
   logic     chain_valid [DIM+1];
   logic     chain_stall [DIM+1];
   logic [31:0] tail_result;

   // register file: always ready, writes to unmapped offsets drop
   assign pready    = 1'b1;
   assign reg_idx   = paddr[AW-1:2];
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      amp_in = amp_ff;
      inv_in = inv_ff;
      prdata = '0;
      if (reg_idx == REG_AMPLITUDE) prdata = {16'b0, amp_ff};
      for (int k = 0; k < DIM; k++)
         if (reg_idx == REG_INV_LENGTH_0 + RIDX_W'(k)) prdata = {16'b0, inv_ff[k]};
      if (cfg_write) begin
         if (reg_idx == REG_AMPLITUDE) amp_in = pwdata[15:0];
         for (int k = 0; k < DIM; k++)
            if (reg_idx == REG_INV_LENGTH_0 + RIDX_W'(k)) inv_in[k] = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff <= CFG_RESET;
         for (int k = 0; k < DIM; k++) inv_ff[k] <= CFG_RESET;
      end else begin
         amp_ff <= amp_in;
         inv_ff <= inv_in;
      end
   end

   // head of the chain: pack the transfer, seed the lengthscale vector
   always_comb begin
      chain_item[0] = '0;
      chain_item[0].action       = action_type'(req_action);
      chain_item[0].first_index  = req_first_index;
      chain_item[0].second_index = req_second_index;
      chain_item[0].pa[0] = req_point_a_0;
      chain_item[0].pa[1] = req_point_a_1;
      chain_item[0].pa[2] = req_point_a_2;
      chain_item[0].pa[3] = req_point_a_3;
      chain_item[0].pb[0] = req_point_b_0;
      chain_item[0].pb[1] = req_point_b_1;
      chain_item[0].pb[2] = req_point_b_2;
      chain_item[0].pb[3] = req_point_b_3;
      chain_item[0].s     = inv_ff;
   end
   assign chain_valid[0] = req_valid;
   assign req_stall      = chain_stall[0];

   // one cell per dimension; each consumes the leading coordinate and rotates
   for (genvar g = 0; g < DIM; g++) begin : g_cell
      ardk_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_item   (chain_item[g]),
         .in_stall  (chain_stall[g]),
         .out_valid (chain_valid[g+1]),
         .out_item  (chain_item[g+1]),
         .out_stall (chain_stall[g+1])
      );
   end

   ardk_tail u_tail (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (chain_valid[DIM]),
      .in_item       (chain_item[DIM]),
      .amp           (amp_ff),
      .in_stall      (chain_stall[DIM]),
      .out_valid     (rsp_valid),
      .out_result    (tail_result),
      .out_saturated (rsp_saturated),
      .out_bad_index (rsp_bad_index),
      .out_stall     (rsp_stall)
   );
   assign rsp_kernel_result = $signed(tail_result);

   // a bad index forces a clean zero
   `ARDK_ASSERT(a_bad_zero, clock, reset, rsp_valid && rsp_bad_index |-> rsp_kernel_result == 32'sd0 && !rsp_saturated)
   // a clipped value sits on one of the two bounds
   `ARDK_ASSERT(a_sat_bound, clock, reset, rsp_valid && rsp_saturated |-> (tail_result == 32'h7FFF_FFFF || tail_result == 32'h8000_0000))
   // backpressure only ever comes from a stalled result
   `ARDK_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall)
   // reset empties the pipeline
   `ARDK_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule
`default_nettype wire
